// ===== design/pfis_pkg.sv =====
// shared types and constants for the pid controller with integral separation
// and feedforward; no dependencies, imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package pfis_pkg;

    // sample and gain formats
    localparam int SAMPLE_WIDTH       = 16;
    localparam int GAIN_W             = 16;
    localparam int GAIN_FRACTION_BITS = 8;
    localparam int WEIGHT_BITS        = 16;
    localparam int WEIGHT_W           = WEIGHT_BITS + 1;
    localparam int PERIOD_W           = 16;
    localparam int THR_W              = 16;

    // derived datapath widths
    localparam int ERR_W   = SAMPLE_WIDTH + 1;
    localparam int DIFF_W  = SAMPLE_WIDTH + 2;
    localparam int MAG_W   = (ERR_W > THR_W) ? ERR_W : THR_W;
    localparam int INTEG_W = 32;
    localparam int SUM_W   = INTEG_W + 1;
    localparam int DRV_W   = SAMPLE_WIDTH + 1;
    localparam int OLIM_W  = 15;
    localparam int ILIM_W  = 31;
    localparam int SEP_W   = 33;
    localparam int FFS_W   = 50;

    // serial multiply-accumulate unit
    localparam int ACC_W = 64;
    localparam int MB_W  = (WEIGHT_W > PERIOD_W) ? WEIGHT_W : PERIOD_W;
    localparam int CNT_W = $clog2(MB_W + 1);

    // stream payloads, packed to whole bytes
    localparam int IN_BITS     = 2 * SAMPLE_WIDTH + PERIOD_W;
    localparam int OUT_BITS    = 3 * SAMPLE_WIDTH;
    localparam int TDATA_IN_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int TDATA_OUT_W = ((OUT_BITS + 7) / 8) * 8;

    // register port
    localparam int APB_AW = 6;
    localparam int APB_DW = 64;

    // register map, one 64-bit slot per register
    typedef enum logic [2:0] {
        REG_KP   = 3'd0,
        REG_KI   = 3'd1,
        REG_KD   = 3'd2,
        REG_OLIM = 3'd3,
        REG_ILIM = 3'd4,
        REG_SEP  = 3'd5,
        REG_FFG  = 3'd6,
        REG_FFS  = 3'd7
    } reg_idx_t;

    // feedforward modes; any other code switches feedforward off
    localparam logic [1:0] FF_MODE_STEP = 2'd1;
    localparam logic [1:0] FF_MODE_PROP = 2'd2;

    // decoded configuration
    typedef struct packed {
        logic [GAIN_W-1:0] kp;
        logic [GAIN_W-1:0] ki;
        logic [GAIN_W-1:0] kd;
        logic [GAIN_W-1:0] ffg;
        logic [OLIM_W-1:0] olim;
        logic [ILIM_W-1:0] ilim;
        logic              sep_en;
        logic [THR_W-1:0]  sep_begin;
        logic [THR_W-1:0]  sep_stop;
        logic [1:0]        ff_mode;
        logic [THR_W-1:0]  ff_start;
        logic [THR_W-1:0]  ff_step;
        logic [THR_W-1:0]  ff_lim;
    } cfg_t;

    // command to the serial multiply-accumulate unit
    typedef struct packed {
        logic             start;
        logic             b_signed;
        logic [CNT_W-1:0] steps;
    } mac_cmd_t;

endpackage

`default_nettype wire

// ===== design/pfis_cfg.sv =====
// register file behind the apb-style configuration port
// depends on pfis_pkg for the register map and the cfg_t bundle
`timescale 1ns / 1ps
`default_nettype none

module pfis_cfg (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [pfis_pkg::APB_AW-1:0]  paddr,
    input  logic [pfis_pkg::APB_DW-1:0]  pwdata,
    output logic [pfis_pkg::APB_DW-1:0]  prdata,
    output logic                         pready,
    output pfis_pkg::cfg_t               cfg
);
    import pfis_pkg::*;

    logic [GAIN_W-1:0] kp_reg;
    logic [GAIN_W-1:0] ki_reg;
    logic [GAIN_W-1:0] kd_reg;
    logic [GAIN_W-1:0] ffg_reg;
    logic [OLIM_W-1:0] olim_reg;
    logic [ILIM_W-1:0] ilim_reg;
    logic [SEP_W-1:0]  sep_reg;
    logic [FFS_W-1:0]  ffs_reg;
    logic              wr_en;
    reg_idx_t          idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = reg_idx_t'(paddr[APB_AW-1:3]);

    // register writes on the access phase of a transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_reg   <= '0;
            ki_reg   <= '0;
            kd_reg   <= '0;
            ffg_reg  <= '0;
            olim_reg <= '1;
            ilim_reg <= '1;
            sep_reg  <= '0;
            ffs_reg  <= '0;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_KP:   kp_reg   <= pwdata[GAIN_W-1:0];
                REG_KI:   ki_reg   <= pwdata[GAIN_W-1:0];
                REG_KD:   kd_reg   <= pwdata[GAIN_W-1:0];
                REG_OLIM: olim_reg <= pwdata[OLIM_W-1:0];
                REG_ILIM: ilim_reg <= pwdata[ILIM_W-1:0];
                REG_SEP:  sep_reg  <= pwdata[SEP_W-1:0];
                REG_FFG:  ffg_reg  <= pwdata[GAIN_W-1:0];
                REG_FFS:  ffs_reg  <= pwdata[FFS_W-1:0];
                default:  kp_reg   <= kp_reg;
            endcase
        end
    end

    // read back
    always_comb
    begin
        unique case (idx)
            REG_KP:   prdata = APB_DW'(kp_reg);
            REG_KI:   prdata = APB_DW'(ki_reg);
            REG_KD:   prdata = APB_DW'(kd_reg);
            REG_OLIM: prdata = APB_DW'(olim_reg);
            REG_ILIM: prdata = APB_DW'(ilim_reg);
            REG_SEP:  prdata = APB_DW'(sep_reg);
            REG_FFG:  prdata = APB_DW'(ffg_reg);
            REG_FFS:  prdata = APB_DW'(ffs_reg);
            default:  prdata = '0;
        endcase
    end

    // field decode
    always_comb
    begin
        cfg.kp        = kp_reg;
        cfg.ki        = ki_reg;
        cfg.kd        = kd_reg;
        cfg.ffg       = ffg_reg;
        cfg.olim      = olim_reg;
        cfg.ilim      = ilim_reg;
        cfg.sep_en    = sep_reg[32];
        cfg.sep_begin = sep_reg[31:16];
        cfg.sep_stop  = sep_reg[15:0];
        cfg.ff_mode   = ffs_reg[49:48];
        cfg.ff_start  = ffs_reg[47:32];
        cfg.ff_step   = ffs_reg[31:16];
        cfg.ff_lim    = ffs_reg[15:0];
    end

endmodule

`default_nettype wire

// ===== design/pfis_sdiv.sv =====
// restoring divider, one quotient bit per cycle, for the separation weight
// (num * 2^WEIGHT_BITS) / den with num <= den; depends on pfis_pkg
`timescale 1ns / 1ps
`default_nettype none

module pfis_sdiv (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [pfis_pkg::THR_W-1:0]     num,
    input  logic [pfis_pkg::THR_W-1:0]     den,
    output logic                           busy,
    output logic [pfis_pkg::WEIGHT_W-1:0]  quot
);
    import pfis_pkg::*;

    logic [THR_W:0]       rem_reg;
    logic [THR_W:0]       rem_next;
    logic [THR_W:0]       rem_sel;
    logic [THR_W+1:0]     trial;
    logic [THR_W-1:0]     den_reg;
    logic [THR_W-1:0]     den_next;
    logic [WEIGHT_W-1:0]  quot_reg;
    logic [WEIGHT_W-1:0]  quot_next;
    logic [CNT_W-1:0]     cnt_reg;
    logic [CNT_W-1:0]     cnt_next;
    logic                 fits;

    assign busy = (cnt_reg != '0);
    assign quot = quot_reg;

    // trial subtract, keep the remainder when it goes negative
    always_comb
    begin
        trial    = {1'b0, rem_reg} - {2'b00, den_reg};
        fits     = !trial[THR_W+1];
        rem_sel  = fits ? trial[THR_W:0] : rem_reg;
        rem_next = rem_reg;
        den_next = den_reg;
        quot_next = quot_reg;
        cnt_next = cnt_reg;
        priority if (start)
        begin
            rem_next  = {1'b0, num};
            den_next  = den;
            quot_next = '0;
            cnt_next  = CNT_W'(WEIGHT_W);
        end
        else if (busy)
        begin
            rem_next  = {rem_sel[THR_W-1:0], 1'b0};
            quot_next = {quot_reg[WEIGHT_W-2:0], fits};
            cnt_next  = cnt_reg - CNT_W'(1);
        end
    end

    // step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // remainder and quotient shift registers
    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        quot_reg <= quot_next;
    end

endmodule

`default_nettype wire

// ===== design/pfis_smac.sv =====
// serial multiply-accumulate: the multiplier word is shifted out one bit per
// cycle, the multiplicand shifts left and is added in; depends on pfis_pkg
`timescale 1ns / 1ps
`default_nettype none

module pfis_smac (
    input  logic                               clk,
    input  logic                               rst_n,
    input  pfis_pkg::mac_cmd_t                 cmd,
    input  logic signed [pfis_pkg::ACC_W-1:0]  a,
    input  logic [pfis_pkg::MB_W-1:0]          b,
    input  logic signed [pfis_pkg::ACC_W-1:0]  acc_init,
    output logic                               busy,
    output logic signed [pfis_pkg::ACC_W-1:0]  acc
);
    import pfis_pkg::*;

    logic signed [ACC_W-1:0] a_reg;
    logic signed [ACC_W-1:0] a_next;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;
    logic signed [ACC_W-1:0] addend;
    logic [MB_W-1:0]         b_reg;
    logic [MB_W-1:0]         b_next;
    logic [CNT_W-1:0]        cnt_reg;
    logic [CNT_W-1:0]        cnt_next;
    logic                    sgn_reg;
    logic                    sgn_next;
    logic                    last_step;

    assign busy = (cnt_reg != '0);
    assign acc  = acc_reg;

    // the top bit of a signed multiplier has negative weight
    always_comb
    begin
        last_step = (cnt_reg == CNT_W'(1));
        addend    = b_reg[0] ? a_reg : '0;
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        sgn_next  = sgn_reg;
        priority if (cmd.start)
        begin
            a_next   = a;
            b_next   = b;
            acc_next = acc_init;
            cnt_next = cmd.steps;
            sgn_next = cmd.b_signed;
        end
        else if (busy)
        begin
            acc_next = (last_step && sgn_reg) ? (acc_reg - addend) : (acc_reg + addend);
            a_next   = a_reg <<< 1;
            b_next   = b_reg >> 1;
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    // step counter and multiplier sign mode
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            sgn_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            sgn_reg <= sgn_next;
        end
    end

    // operand shift registers and accumulator
    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end

endmodule

`default_nettype wire

// ===== design/pid_feedforward_integral_separation_top.sv =====
// Positional PID controller with integral separation and feedforward. An
// accepted sample is worked on alone: the error, the integral update, the
// weighted I, P and D terms and the feedforward term are formed by one
// bit-serial multiply-accumulate unit, one multiplier bit per cycle, in six
// multiplications one after another, while a restoring divider forms the
// separation weight one bit per cycle alongside the first of them. The next
// item can be accepted once its result has moved into the output register.
// The result waits in an output register, so a stalled consumer only holds
// the block once a second result is ready.
// Depends on pfis_pkg, pfis_cfg, pfis_sdiv and pfis_smac.
`timescale 1ns / 1ps
`default_nettype none

module pid_feedforward_integral_separation_top (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [pfis_pkg::APB_AW-1:0]       paddr,
    input  logic [pfis_pkg::APB_DW-1:0]       pwdata,
    output logic [pfis_pkg::APB_DW-1:0]       prdata,
    output logic                              pready,
    // input samples
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // target_value, measured_value, sample_period (from bit 0 up)
    input  logic [pfis_pkg::TDATA_IN_W-1:0]   s_axis_tdata,
    // results
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // drive_out, pid_part, feedforward_part (from bit 0 up)
    output logic [pfis_pkg::TDATA_OUT_W-1:0]  m_axis_tdata
);
    import pfis_pkg::*;

    typedef enum logic [9:0] {
        ST_IDLE = 10'b0000000001,
        ST_PREP = 10'b0000000010,
        ST_MINC = 10'b0000000100,
        ST_INTG = 10'b0000001000,
        ST_MIW  = 10'b0000010000,
        ST_MKI  = 10'b0000100000,
        ST_MKP  = 10'b0001000000,
        ST_MKD  = 10'b0010000000,
        ST_MFF  = 10'b0100000000,
        ST_FIN  = 10'b1000000000
    } state_t;

    localparam logic [WEIGHT_W-1:0] W_ONE = {1'b1, {WEIGHT_BITS{1'b0}}};
    localparam logic signed [ACC_W-1:0] HALF_P = ACC_W'(64'sd1 <<< (PERIOD_W - 1));
    localparam logic signed [ACC_W-1:0] HALF_W = ACC_W'(64'sd1 <<< (WEIGHT_BITS - 1));
    localparam logic signed [ACC_W-1:0] HALF_G = (GAIN_FRACTION_BITS == 0) ? '0 :
        ACC_W'(64'sd1 <<< (GAIN_FRACTION_BITS - 1));
    localparam logic signed [ACC_W-1:0] SMAX = ACC_W'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 1);
    localparam logic signed [ACC_W-1:0] SMIN = -SMAX - ACC_W'(64'sd1);

    cfg_t                        cfg;
    state_t                      state_reg;
    state_t                      state_next;

    logic signed [SAMPLE_WIDTH-1:0] tgt_reg;
    logic signed [SAMPLE_WIDTH-1:0] tgt_next;
    logic signed [ERR_W-1:0]     err_reg;
    logic signed [ERR_W-1:0]     err_next;
    logic [PERIOD_W-1:0]         per_reg;
    logic [PERIOD_W-1:0]         per_next;
    logic [WEIGHT_W-1:0]         w_reg;
    logic [WEIGHT_W-1:0]         w_next;
    logic                        accum_reg;
    logic                        accum_next;
    logic                        use_div_reg;
    logic                        use_div_next;
    logic signed [INTEG_W-1:0]   integ_reg;
    logic signed [INTEG_W-1:0]   integ_next;
    logic signed [ERR_W-1:0]     prev_reg;
    logic signed [ERR_W-1:0]     prev_next;
    logic signed [SAMPLE_WIDTH-1:0] pid_reg;
    logic signed [SAMPLE_WIDTH-1:0] pid_next;
    logic signed [SAMPLE_WIDTH-1:0] ff_reg;
    logic signed [SAMPLE_WIDTH-1:0] ff_next;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic [SAMPLE_WIDTH-1:0]     out_drive_reg;
    logic [SAMPLE_WIDTH-1:0]     out_pid_reg;
    logic [SAMPLE_WIDTH-1:0]     out_ff_reg;
    logic                        out_load;

    // input unpacking
    logic                        in_xfer;
    logic signed [SAMPLE_WIDTH-1:0] in_tgt;
    logic signed [SAMPLE_WIDTH-1:0] in_meas;
    logic [PERIOD_W-1:0]         in_per;

    // separation decision
    logic signed [ERR_W-1:0]     err_neg;
    logic [ERR_W-1:0]            mag;
    logic [MAG_W-1:0]            mag_x;
    logic [MAG_W-1:0]            beg_x;
    logic [MAG_W-1:0]            stop_x;
    logic [MAG_W-1:0]            num_x;
    logic                        sep_above;
    logic                        sep_band;

    // divider and multiply-accumulate connections
    logic                        div_start;
    logic                        div_busy;
    logic [WEIGHT_W-1:0]         div_quot;
    logic [THR_W-1:0]            div_num;
    logic [THR_W-1:0]            div_den;
    mac_cmd_t                    mac_cmd;
    logic signed [ACC_W-1:0]     mac_a;
    logic [MB_W-1:0]             mac_b;
    logic signed [ACC_W-1:0]     mac_init;
    logic                        mac_busy;
    logic signed [ACC_W-1:0]     mac_acc;

    // arithmetic between the multiplications
    logic signed [ACC_W-1:0]     inc_rnd;
    logic signed [SUM_W-1:0]     integ_add;
    logic signed [SUM_W-1:0]     integ_sum;
    logic signed [SUM_W-1:0]     ilim_pos;
    logic signed [SUM_W-1:0]     ilim_neg;
    logic signed [SUM_W-1:0]     integ_clamp;
    logic signed [ACC_W-1:0]     rnd_w;
    logic signed [ACC_W-1:0]     rnd_g;
    logic signed [DIFF_W-1:0]    diff;
    logic signed [ACC_W-1:0]     olim_pos;
    logic signed [ACC_W-1:0]     olim_neg;
    logic signed [ACC_W-1:0]     pid_clamp;
    logic signed [ACC_W-1:0]     fflim_pos;
    logic signed [ACC_W-1:0]     fflim_neg;
    logic signed [ACC_W-1:0]     ff_prop;
    logic signed [ACC_W-1:0]     ff_sat;
    logic signed [ERR_W-1:0]     tgt_x;
    logic signed [ERR_W-1:0]     start_pos;
    logic signed [ERR_W-1:0]     start_neg;
    logic signed [ERR_W-1:0]     step_x;
    logic signed [ERR_W-1:0]     ff_a;
    logic signed [DRV_W-1:0]     drv_sum;
    logic signed [DRV_W-1:0]     olim_d;
    logic signed [DRV_W-1:0]     drv_clamp;

    pfis_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pfis_sdiv u_sdiv (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .busy  (div_busy),
        .quot  (div_quot)
    );

    pfis_smac u_smac (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (mac_cmd),
        .a        (mac_a),
        .b        (mac_b),
        .acc_init (mac_init),
        .busy     (mac_busy),
        .acc      (mac_acc)
    );

    // stream handshakes
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign in_tgt        = s_axis_tdata[SAMPLE_WIDTH-1:0];
    assign in_meas       = s_axis_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];
    assign in_per        = s_axis_tdata[2*SAMPLE_WIDTH+PERIOD_W-1:2*SAMPLE_WIDTH];
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = TDATA_OUT_W'({out_ff_reg, out_pid_reg, out_drive_reg});

    // error magnitude against the separation thresholds
    always_comb
    begin
        err_neg   = -err_reg;
        mag       = err_reg[ERR_W-1] ? err_neg : err_reg;
        mag_x     = MAG_W'(mag);
        beg_x     = MAG_W'(cfg.sep_begin);
        stop_x    = MAG_W'(cfg.sep_stop);
        num_x     = beg_x - mag_x;
        sep_above = cfg.sep_en && (mag_x > beg_x);
        sep_band  = cfg.sep_en && !sep_above && (mag_x >= stop_x)
                    && (cfg.sep_begin > cfg.sep_stop);
        div_num   = num_x[THR_W-1:0];
        div_den   = cfg.sep_begin - cfg.sep_stop;
    end

    // integral increment, round half up, then clamp
    always_comb
    begin
        inc_rnd     = (mac_acc + HALF_P) >>> PERIOD_W;
        integ_add   = accum_reg ? SUM_W'(inc_rnd) : '0;
        integ_sum   = SUM_W'(integ_reg) + integ_add;
        ilim_pos    = $signed(SUM_W'(cfg.ilim));
        ilim_neg    = -ilim_pos;
        integ_clamp = (integ_sum < ilim_neg) ? ilim_neg :
                      (integ_sum > ilim_pos) ? ilim_pos : integ_sum;
    end

    // rounding of the accumulator and output clamps
    always_comb
    begin
        rnd_w     = (mac_acc + HALF_W) >>> WEIGHT_BITS;
        rnd_g     = (mac_acc + HALF_G) >>> GAIN_FRACTION_BITS;
        diff      = DIFF_W'(err_reg) - DIFF_W'(prev_reg);
        olim_pos  = $signed(ACC_W'(cfg.olim));
        olim_neg  = -olim_pos;
        pid_clamp = (rnd_g < olim_neg) ? olim_neg :
                    (rnd_g > olim_pos) ? olim_pos : rnd_g;
        fflim_pos = $signed(ACC_W'(cfg.ff_lim));
        fflim_neg = -fflim_pos;
        ff_prop   = rnd_g;
        if (cfg.ff_mode == FF_MODE_PROP)
        begin
            ff_prop = (rnd_g < fflim_neg) ? fflim_neg :
                      (rnd_g > fflim_pos) ? fflim_pos : rnd_g;
        end
        ff_sat    = (ff_prop < SMIN) ? SMIN : (ff_prop > SMAX) ? SMAX : ff_prop;
    end

    // feedforward multiplicand: step value, its negation, the target or zero
    always_comb
    begin
        tgt_x     = ERR_W'(tgt_reg);
        start_pos = $signed(ERR_W'(cfg.ff_start));
        start_neg = -start_pos;
        step_x    = ERR_W'($signed(cfg.ff_step));
        ff_a      = '0;
        priority if (cfg.ff_mode == FF_MODE_STEP)
        begin
            priority if (tgt_x > start_pos)
            begin
                ff_a = step_x;
            end
            else if (tgt_x < start_neg)
            begin
                ff_a = -step_x;
            end
        end
        else if (cfg.ff_mode == FF_MODE_PROP)
        begin
            ff_a = tgt_x;
        end
    end

    // final drive clamp
    always_comb
    begin
        drv_sum   = DRV_W'(ff_reg) + DRV_W'(pid_reg);
        olim_d    = $signed(DRV_W'(cfg.olim));
        drv_clamp = (drv_sum < -olim_d) ? -olim_d :
                    (drv_sum > olim_d) ? olim_d : drv_sum;
    end

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        tgt_next     = tgt_reg;
        err_next     = err_reg;
        per_next     = per_reg;
        w_next       = w_reg;
        accum_next   = accum_reg;
        use_div_next = use_div_reg;
        integ_next   = integ_reg;
        prev_next    = prev_reg;
        pid_next     = pid_reg;
        ff_next      = ff_reg;
        out_load     = 1'b0;
        div_start    = 1'b0;
        mac_cmd      = '0;
        mac_a        = '0;
        mac_b        = '0;
        mac_init     = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    tgt_next   = in_tgt;
                    err_next   = ERR_W'(in_tgt) - ERR_W'(in_meas);
                    per_next   = in_per;
                    state_next = ST_PREP;
                end
            end
            // weight decision, division and error times period start together
            ST_PREP:
            begin
                div_start        = sep_band;
                w_next           = sep_above ? '0 : W_ONE;
                accum_next       = !sep_above;
                use_div_next     = sep_band;
                mac_cmd.start    = 1'b1;
                mac_cmd.b_signed = 1'b0;
                mac_cmd.steps    = CNT_W'(PERIOD_W);
                mac_a            = ACC_W'(err_reg);
                mac_b            = MB_W'(per_reg);
                state_next       = ST_MINC;
            end
            ST_MINC:
            begin
                if (!mac_busy && !div_busy)
                begin
                    if (use_div_reg)
                    begin
                        w_next = div_quot;
                    end
                    state_next = ST_INTG;
                end
            end
            // integral update, then integral times weight
            ST_INTG:
            begin
                integ_next       = INTEG_W'(integ_clamp);
                mac_cmd.start    = 1'b1;
                mac_cmd.b_signed = 1'b0;
                mac_cmd.steps    = CNT_W'(WEIGHT_W);
                mac_a            = ACC_W'(integ_clamp);
                mac_b            = MB_W'(w_reg);
                state_next       = ST_MIW;
            end
            ST_MIW:
            begin
                if (!mac_busy)
                begin
                    mac_cmd.start    = 1'b1;
                    mac_cmd.b_signed = 1'b1;
                    mac_cmd.steps    = CNT_W'(GAIN_W);
                    mac_a            = mac_acc;
                    mac_b            = MB_W'($signed(cfg.ki));
                    state_next       = ST_MKI;
                end
            end
            // rounded I term seeds the P accumulation
            ST_MKI:
            begin
                if (!mac_busy)
                begin
                    mac_cmd.start    = 1'b1;
                    mac_cmd.b_signed = 1'b1;
                    mac_cmd.steps    = CNT_W'(GAIN_W);
                    mac_a            = ACC_W'(err_reg);
                    mac_b            = MB_W'($signed(cfg.kp));
                    mac_init         = rnd_w;
                    state_next       = ST_MKP;
                end
            end
            ST_MKP:
            begin
                if (!mac_busy)
                begin
                    mac_cmd.start    = 1'b1;
                    mac_cmd.b_signed = 1'b1;
                    mac_cmd.steps    = CNT_W'(GAIN_W);
                    mac_a            = ACC_W'(diff);
                    mac_b            = MB_W'($signed(cfg.kd));
                    mac_init         = mac_acc;
                    state_next       = ST_MKD;
                end
            end
            // pid sum done, start the feedforward product
            ST_MKD:
            begin
                if (!mac_busy)
                begin
                    pid_next         = pid_clamp[SAMPLE_WIDTH-1:0];
                    mac_cmd.start    = 1'b1;
                    mac_cmd.b_signed = 1'b1;
                    mac_cmd.steps    = CNT_W'(GAIN_W);
                    mac_a            = ACC_W'(ff_a);
                    mac_b            = MB_W'($signed(cfg.ffg));
                    state_next       = ST_MFF;
                end
            end
            ST_MFF:
            begin
                if (!mac_busy)
                begin
                    ff_next    = ff_sat[SAMPLE_WIDTH-1:0];
                    state_next = ST_FIN;
                end
            end
            // hand the result to the output register once it is free
            ST_FIN:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_load   = 1'b1;
                    prev_next  = err_reg;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid_next = out_load ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_reg);

    // control state and controller memory
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            integ_reg     <= '0;
            prev_reg      <= '0;
            out_valid_reg <= 1'b0;
            accum_reg     <= 1'b0;
            use_div_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            integ_reg     <= integ_next;
            prev_reg      <= prev_next;
            out_valid_reg <= out_valid_next;
            accum_reg     <= accum_next;
            use_div_reg   <= use_div_next;
        end
    end

    // per-item payload registers
    always_ff @(posedge clk)
    begin
        tgt_reg <= tgt_next;
        err_reg <= err_next;
        per_reg <= per_next;
        w_reg   <= w_next;
        pid_reg <= pid_next;
        ff_reg  <= ff_next;
        if (out_load)
        begin
            out_drive_reg <= drv_clamp[SAMPLE_WIDTH-1:0];
            out_pid_reg   <= pid_reg;
            out_ff_reg    <= ff_reg;
        end
    end

endmodule

`default_nettype wire

// ===== dv/pid_feedforward_integral_separation_top_tb.sv =====
// self-checking testbench for the pid controller with integral separation and feedforward
// depends on pfis_pkg and the design top pid_feedforward_integral_separation_top
`timescale 1ns / 1ps

module pid_feedforward_integral_separation_top_tb;

    import pfis_pkg::*;

    // one result transfer, split into its fields
    typedef struct {
        logic [15:0] drive;
        logic [15:0] pid;
        logic [15:0] ff;
    } control_result_t;

    logic                   clk;
    logic                   rst_n;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [APB_AW-1:0]      paddr;
    logic [APB_DW-1:0]      pwdata;
    logic [APB_DW-1:0]      prdata;
    logic                   pready;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    // target_value, measured_value, sample_period (from bit 0 up)
    logic [TDATA_IN_W-1:0]  s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    // drive_out, pid_part, feedforward_part (from bit 0 up)
    logic [TDATA_OUT_W-1:0] m_axis_tdata;

    // controller registers as last written, and the controller state
    logic [63:0]     reg_copy [0:7];
    longint          integral_acc;
    longint          last_error;

    control_result_t expected_q [$];

    int sender_idle_rate;
    int sink_stall_rate;
    int mismatch_count;
    int results_checked;
    int samples_sent;
    int settings_applied;
    int drains_done;

    pid_feedforward_integral_separation_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // run limit
    initial
    begin
        #20_000_000;
        $display("FAILURE");
        $finish;
    end

    // ---------------------------------------------------------------- predictor

    function automatic longint round_half_up(input longint v, input int sh);
        return (v + (longint'(1) <<< (sh - 1))) >>> sh;
    endfunction

    function automatic longint clamp_to(input longint v, input longint lo, input longint hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic logic [63:0] reg_mask(input reg_idx_t idx);
        case (idx)
            REG_OLIM: return (64'd1 << OLIM_W) - 1;
            REG_ILIM: return (64'd1 << ILIM_W) - 1;
            REG_SEP:  return (64'd1 << SEP_W) - 1;
            REG_FFS:  return (64'd1 << FFS_W) - 1;
            default:  return (64'd1 << GAIN_W) - 1;
        endcase
    endfunction

    // one control step: updates the integral and previous error, returns the outputs
    function automatic control_result_t predict_control(input logic [15:0] tgt_raw,
                                                        input logic [15:0] meas_raw,
                                                        input logic [15:0] period_raw);
        longint          tgt, meas, per, err, mag, weight;
        longint          kp, ki, kd, ffg, olim, ilim;
        longint          begin_thr, stop_thr, start_thr, step_val, ff_lim;
        longint          sum, pid, ff, drive;
        logic [1:0]      mode;
        bit              accumulate;
        control_result_t res;
        tgt       = longint'($signed(tgt_raw));
        meas      = longint'($signed(meas_raw));
        per       = longint'(period_raw);
        kp        = longint'($signed(reg_copy[REG_KP][15:0]));
        ki        = longint'($signed(reg_copy[REG_KI][15:0]));
        kd        = longint'($signed(reg_copy[REG_KD][15:0]));
        ffg       = longint'($signed(reg_copy[REG_FFG][15:0]));
        olim      = longint'(reg_copy[REG_OLIM][14:0]);
        ilim      = longint'(reg_copy[REG_ILIM][30:0]);
        begin_thr = longint'(reg_copy[REG_SEP][31:16]);
        stop_thr  = longint'(reg_copy[REG_SEP][15:0]);
        mode      = reg_copy[REG_FFS][49:48];
        start_thr = longint'(reg_copy[REG_FFS][47:32]);
        step_val  = longint'($signed(reg_copy[REG_FFS][31:16]));
        ff_lim    = longint'(reg_copy[REG_FFS][15:0]);

        err        = tgt - meas;
        mag        = (err < 0) ? -err : err;
        weight     = longint'(1) <<< WEIGHT_BITS;
        accumulate = 1'b1;

        // integral separation: frozen above begin, falling weight between the thresholds
        if (reg_copy[REG_SEP][32])
        begin
            if (mag > begin_thr)
            begin
                weight     = 0;
                accumulate = 1'b0;
            end
            else if (mag >= stop_thr && begin_thr > stop_thr)
                weight = ((begin_thr - mag) <<< WEIGHT_BITS) / (begin_thr - stop_thr);
        end
        if (accumulate)
            integral_acc = integral_acc + round_half_up(err * per, 16);
        integral_acc = clamp_to(integral_acc, -ilim, ilim);

        sum = kp * err + kd * (err - last_error)
            + round_half_up(ki * integral_acc * weight, WEIGHT_BITS);
        pid = clamp_to(round_half_up(sum, GAIN_FRACTION_BITS), -olim, olim);
        last_error = err;

        // feedforward from the setpoint
        ff = 0;
        if (mode == FF_MODE_STEP)
        begin
            if (tgt > 0 && tgt > start_thr)
                ff = round_half_up(step_val * ffg, GAIN_FRACTION_BITS);
            else if (tgt < 0 && tgt < -start_thr)
                ff = round_half_up(-step_val * ffg, GAIN_FRACTION_BITS);
        end
        else if (mode == FF_MODE_PROP)
            ff = clamp_to(round_half_up(ffg * tgt, GAIN_FRACTION_BITS), -ff_lim, ff_lim);
        ff = clamp_to(ff, -32768, 32767);

        drive = clamp_to(ff + pid, -olim, olim);

        res.drive = drive[15:0];
        res.pid   = pid[15:0];
        res.ff    = ff[15:0];
        return res;
    endfunction

    // ---------------------------------------------------------------- drivers

    // register write over the configuration port, setup then access
    task automatic write_register(input reg_idx_t idx, input logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        reg_copy[idx] = value & reg_mask(idx);
    endtask

    // one sample transfer, with an optional idle burst ahead of it
    task automatic send_sample(input logic [15:0] target, input logic [15:0] measured,
                               input logic [15:0] period);
        if (sender_idle_rate != 0 && $urandom_range(1, sender_idle_rate) == 1)
        begin
            s_axis_tvalid <= 1'b0;
            // sometimes let the gap fall just as the block frees up
            if ($urandom_range(0, 1) == 1)
                while (expected_q.size() != 0)
                    @(posedge clk);
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {period, measured, target};
        do
            @(posedge clk);
        while (s_axis_tready !== 1'b1);
        expected_q.push_back(predict_control(target, measured, period));
        samples_sent++;
    endtask

    // stop sending and wait until every expected result has come back
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        drains_done++;
    endtask

    // ---------------------------------------------------------------- checker

    function automatic void compare_field(input string label, input logic [15:0] want,
                                          input logic [15:0] got);
        if (got !== want)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("mismatch on %s, result %0d: expected %0d, got %0d",
                         label, results_checked, $signed(want), $signed(got));
        end
    endfunction

    task automatic check_result(input logic [TDATA_OUT_W-1:0] data);
        control_result_t want;
        if (expected_q.size() == 0)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("unexpected result transfer, data %h", data);
        end
        else
        begin
            want = expected_q.pop_front();
            compare_field("drive_out", want.drive, data[15:0]);
            compare_field("pid_part", want.pid, data[31:16]);
            compare_field("feedforward_part", want.ff, data[47:32]);
        end
        results_checked++;
    endtask

    // result sink with random stall bursts
    initial
    begin : result_sink
        int stall_left;
        stall_left = 0;
        m_axis_tready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1)
                check_result(m_axis_tdata);
            if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else if (sink_stall_rate != 0 && $urandom_range(1, sink_stall_rate) == 1)
            begin
                stall_left = $urandom_range(0, 3);
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // ---------------------------------------------------------------- tests

    // gains at reset are zero, so only the integral moves
    task automatic test_reset_state();
        send_sample(16'h7fff, 16'h8000, 16'hffff);
        send_sample(16'h8000, 16'h7fff, 16'h0000);
        drain_results();
    endtask

    // field extremes, negative gain and both clamps
    task automatic test_gains_and_limits();
        write_register(REG_KP, 64'h0100);
        write_register(REG_KI, 64'h0080);
        write_register(REG_KD, 64'h8000);
        send_sample(16'h4000, 16'h0000, 16'h8000);
        send_sample(16'h7fff, 16'h8000, 16'hffff);
        send_sample(16'h8000, 16'h7fff, 16'hffff);
        send_sample(16'h0000, 16'h0000, 16'h0000);
        drain_results();
        write_register(REG_OLIM, 64'd0);
        write_register(REG_ILIM, 64'd1000);
        send_sample(16'h1000, 16'h0000, 16'hffff);
        drain_results();
        write_register(REG_OLIM, 64'd100);
        send_sample(16'h0000, 16'h1000, 16'h1234);
        drain_results();
    endtask

    // below stop, on stop, between, on begin, above begin, negative error
    task automatic test_integral_separation();
        write_register(REG_KP, 64'h0000);
        write_register(REG_KD, 64'h0000);
        write_register(REG_KI, 64'h0100);
        write_register(REG_OLIM, 64'h7fff);
        write_register(REG_ILIM, 64'h7fff_ffff);
        write_register(REG_SEP, {31'd0, 1'b1, 16'h0800, 16'h0200});
        send_sample(16'h0100, 16'h0000, 16'h4000);
        send_sample(16'h0200, 16'h0000, 16'h4000);
        send_sample(16'h0500, 16'h0000, 16'h4000);
        send_sample(16'h0800, 16'h0000, 16'h4000);
        send_sample(16'h0900, 16'h0000, 16'h4000);
        send_sample(16'hfb00, 16'h0000, 16'h4000);
        drain_results();
        // equal thresholds: full weight up to the threshold, frozen above it
        write_register(REG_SEP, {31'd0, 1'b1, 16'h0400, 16'h0400});
        send_sample(16'h0300, 16'h0000, 16'h4000);
        send_sample(16'h0500, 16'h0000, 16'h4000);
        drain_results();
        // begin below stop
        write_register(REG_SEP, {31'd0, 1'b1, 16'h0100, 16'h0400});
        send_sample(16'h0080, 16'h0000, 16'h4000);
        send_sample(16'h0200, 16'h0000, 16'h4000);
        drain_results();
    endtask

    // step mode either side of the start threshold, saturation, proportional, mode three
    task automatic test_feedforward();
        write_register(REG_KI, 64'h0000);
        write_register(REG_SEP, 64'd0);
        write_register(REG_FFG, 64'h0100);
        write_register(REG_FFS, {14'd0, 2'd1, 16'h0100, 16'h1000, 16'h0000});
        send_sample(16'h0200, 16'h0000, 16'h0000);
        send_sample(16'h0100, 16'h0000, 16'h0000);
        send_sample(16'hfe00, 16'h0000, 16'h0000);
        drain_results();
        write_register(REG_FFG, 64'h8000);
        write_register(REG_FFS, {14'd0, 2'd1, 16'h0000, 16'h8000, 16'h0000});
        send_sample(16'h0001, 16'h0000, 16'h0000);
        drain_results();
        write_register(REG_FFG, 64'h7fff);
        write_register(REG_FFS, {14'd0, 2'd2, 16'h0000, 16'h0000, 16'h0800});
        send_sample(16'h7fff, 16'h0000, 16'h0000);
        send_sample(16'h8000, 16'h0000, 16'h0000);
        drain_results();
        write_register(REG_FFS, {14'd0, 2'd3, 16'h0000, 16'h1000, 16'hffff});
        send_sample(16'h7fff, 16'h0000, 16'h0000);
        drain_results();
    endtask

    function automatic logic [63:0] random_gain();
        case ($urandom_range(0, 3))
            0:       return 64'($urandom_range(0, 2047) - 1024) & 64'hffff;
            1:       return {$urandom, $urandom};
            2:       return ($urandom_range(0, 1) == 1) ? 64'h7fff : 64'h8000;
            default: return 64'h0000;
        endcase
    endfunction

    // phase 1 sets every register to its top, phase 2 to its bottom, the rest are random
    task automatic program_setting(input int phase);
        logic [15:0] begin_thr, stop_thr;
        if (phase == 1)
        begin
            write_register(REG_KP, 64'h7fff);
            write_register(REG_KI, 64'h7fff);
            write_register(REG_KD, 64'h7fff);
            write_register(REG_OLIM, 64'h7fff);
            write_register(REG_ILIM, 64'h7fff_ffff);
            write_register(REG_SEP, 64'h1_ffff_0000);
            write_register(REG_FFG, 64'h7fff);
            write_register(REG_FFS, {14'd0, 2'd2, 16'hffff, 16'h7fff, 16'hffff});
        end
        else if (phase == 2)
        begin
            write_register(REG_KP, 64'h8000);
            write_register(REG_KI, 64'h8000);
            write_register(REG_KD, 64'h8000);
            write_register(REG_OLIM, 64'd0);
            write_register(REG_ILIM, 64'd0);
            write_register(REG_SEP, 64'h1_0000_0000);
            write_register(REG_FFG, 64'h8000);
            write_register(REG_FFS, {14'd0, 2'd1, 16'h0000, 16'h8000, 16'h0000});
        end
        else
        begin
            write_register(REG_KP, random_gain());
            write_register(REG_KI, random_gain());
            write_register(REG_KD, random_gain());
            case ($urandom_range(0, 2))
                0:       write_register(REG_OLIM, 64'h7fff);
                1:       write_register(REG_OLIM, 64'($urandom_range(0, 4000)));
                default: write_register(REG_OLIM, {$urandom, $urandom});
            endcase
            case ($urandom_range(0, 3))
                0:       write_register(REG_ILIM, 64'h7fff_ffff);
                1:       write_register(REG_ILIM, 64'($urandom_range(0, 100000)));
                2:       write_register(REG_ILIM, 64'd0);
                default: write_register(REG_ILIM, {$urandom, $urandom});
            endcase
            // thresholds mostly near the errors that the samples produce
            begin_thr = 16'($urandom_range(0, 3000));
            stop_thr  = 16'($urandom_range(0, begin_thr));
            case ($urandom_range(0, 3))
                0:       write_register(REG_SEP, {31'd0, 1'b1, begin_thr, stop_thr});
                1:       write_register(REG_SEP, {31'd0, 1'b1, stop_thr, begin_thr});
                2:       write_register(REG_SEP, {$urandom, $urandom});
                default: write_register(REG_SEP, {31'd0, 1'b0, begin_thr, stop_thr});
            endcase
            write_register(REG_FFG, random_gain());
            write_register(REG_FFS, {$urandom, $urandom});
        end
        settings_applied++;
    endtask

    task automatic send_random_sample();
        logic [15:0] target, measured, period;
        int          spread;
        target = 16'($urandom);
        spread = $urandom_range(0, 3000);
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4:
                measured = target + 16'($urandom_range(0, 2 * spread) - spread);
            5, 6, 7:
                measured = 16'($urandom);
            default:
            begin
                target   = ($urandom_range(0, 1) == 1) ? 16'h7fff : 16'h8000;
                measured = ($urandom_range(0, 1) == 1) ? 16'h7fff : 16'h8000;
            end
        endcase
        case ($urandom_range(0, 5))
            0:       period = 16'h0000;
            1:       period = 16'hffff;
            2:       period = 16'($urandom_range(0, 255));
            default: period = 16'($urandom);
        endcase
        send_sample(target, measured, period);
    endtask

    // random phases under changing settings; the last one runs without idling
    task automatic test_random_traffic();
        int rates [3];
        rates = '{0, 3, 6};
        for (int phase = 1; phase <= 12; phase++)
        begin
            program_setting(phase);
            sender_idle_rate = (phase == 12) ? 0 : rates[$urandom_range(0, 2)];
            sink_stall_rate  = (phase == 12) ? 0 : rates[$urandom_range(0, 2)];
            for (int n = 0; n < 145; n++)
            begin
                // hold off mid-phase until the pipeline is empty
                if (n == 70)
                    drain_results();
                send_random_sample();
            end
            drain_results();
        end
    endtask

    // ---------------------------------------------------------------- main

    initial
    begin
        rst_n            <= 1'b0;
        psel             <= 1'b0;
        penable          <= 1'b0;
        pwrite           <= 1'b0;
        paddr            <= '0;
        pwdata           <= '0;
        s_axis_tvalid    <= 1'b0;
        s_axis_tdata     <= '0;
        mismatch_count   = 0;
        results_checked  = 0;
        samples_sent     = 0;
        settings_applied = 0;
        drains_done      = 0;
        sender_idle_rate = 4;
        sink_stall_rate  = 4;
        integral_acc     = 0;
        last_error       = 0;
        for (int i = 0; i < 8; i++)
            reg_copy[i] = 64'd0;
        reg_copy[REG_OLIM] = 64'h7fff;
        reg_copy[REG_ILIM] = 64'h7fff_ffff;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_gains_and_limits();
        test_integral_separation();
        test_feedforward();
        test_random_traffic();

        // wait out anything still in flight, bounded
        s_axis_tvalid <= 1'b0;
        for (int i = 0; i < 20000 && expected_q.size() != 0; i++)
            @(posedge clk);
        repeat (120) @(posedge clk);
        if (expected_q.size() != 0)
        begin
            mismatch_count += expected_q.size();
            $display("%0d expected results never arrived", expected_q.size());
        end

        $display("sent %0d samples, checked %0d results across %0d random register settings",
                 samples_sent, results_checked, settings_applied);
        $display("pipeline emptied %0d times, %0d mismatches", drains_done, mismatch_count);
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
